@@ rtl/fieldbus_slave_al_state_machine_assert.svh @@
// Assertion macros for the AL state machine block.
// The macros expect i_clk and i_rst_n to be visible where they are used.
`ifndef FIELDBUS_SLAVE_AL_STATE_MACHINE_ASSERT_SVH
`define FIELDBUS_SLAVE_AL_STATE_MACHINE_ASSERT_SVH

// Checked only while the block is out of reset.
`define FSALSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define FSALSM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/fsalsm_pkg.sv @@
// ----------------------------------------------------------------------------
// fsalsm_pkg
// Types, codes and constants shared by the AL state machine modules.
// ----------------------------------------------------------------------------
package fsalsm_pkg;

    localparam int PD_BUFFER_BYTES   = 32;
    localparam int MIN_MAILBOX_BYTES = 34;
    localparam int Q_DEPTH           = 2;

    localparam int AL_ACK_BIT     = 4;
    localparam int AL_ERR_ACK_BIT = 5;
    localparam int AL_ERR_BIT     = 5;

    // Command codes on the request channel.
    localparam logic [1:0] CMD_POLL   = 2'd0;
    localparam logic [1:0] CMD_SM_WR  = 2'd1;
    localparam logic [1:0] CMD_MAP_WR = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MBX_OUT_START = 3'd0;
    localparam logic [2:0] CFG_MBX_IN_START  = 3'd1;
    localparam logic [2:0] CFG_OUT_START     = 3'd2;
    localparam logic [2:0] CFG_IN_START      = 3'd3;
    localparam logic [2:0] CFG_CTRL_NIBBLES  = 3'd4;
    localparam logic [2:0] CFG_MIN_PDO       = 3'd5;
    localparam logic [2:0] CFG_SKIP_CHECKS   = 3'd6;

    typedef enum logic [3:0] {
        ST_INIT   = 4'd1,
        ST_PREOP  = 4'd2,
        ST_BOOT   = 4'd3,
        ST_SAFEOP = 4'd4,
        ST_OP     = 4'd8
    } t_al_state;

    typedef enum logic [1:0] {
        OP_POLL,
        OP_SM_WR,
        OP_MAP_WR,
        OP_NONE
    } t_op;

    typedef enum logic [2:0] {
        CODE_NONE,
        CODE_BAD_CHANGE,
        CODE_MAILBOX,
        CODE_OUT_CFG,
        CODE_IN_CFG,
        CODE_IN_MAP,
        CODE_OUT_MAP
    } t_err_code;

    typedef struct packed {
        t_op         op;
        logic [5:0]  al_ctrl;
        logic [1:0]  idx;
        logic [15:0] addr;
        logic [15:0] len;
        logic [3:0]  ctrl;
        logic        active;
    } t_req;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_status;

    function automatic logic is_known_state(logic [3:0] code);
        return (code == ST_INIT) || (code == ST_PREOP) || (code == ST_BOOT) ||
               (code == ST_SAFEOP) || (code == ST_OP);
    endfunction

    function automatic logic legal_move(t_al_state from, logic [3:0] to);
        logic ok;
        ok = 1'b0;
        if (to == ST_INIT) begin
            ok = 1'b1;
        end else begin
            case (from)
                ST_INIT:   ok = (to == ST_PREOP);
                ST_PREOP:  ok = (to == ST_SAFEOP);
                ST_SAFEOP: ok = (to == ST_OP) || (to == ST_PREOP);
                ST_OP:     ok = (to == ST_SAFEOP);
                default:   ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

endpackage

@@ rtl/fsalsm_in_if.sv @@
// ----------------------------------------------------------------------------
// fsalsm_in_if
// Request channel: AL control polls and table entry writes.
// ----------------------------------------------------------------------------
interface fsalsm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [7:0]  al_control;
    logic [1:0]  entry_index;
    logic [15:0] entry_address;
    logic [15:0] entry_length;
    logic [7:0]  entry_control;
    logic        entry_active;

    modport source (
        output valid, command, al_control, entry_index, entry_address,
               entry_length, entry_control, entry_active,
        input  ready
    );

    modport sink (
        input  valid, command, al_control, entry_index, entry_address,
               entry_length, entry_control, entry_active,
        output ready
    );
endinterface

@@ rtl/fsalsm_out_if.sv @@
// ----------------------------------------------------------------------------
// fsalsm_out_if
// Response channel: slave state and AL status after each request.
// ----------------------------------------------------------------------------
interface fsalsm_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] current_state;
    logic [7:0] al_status;
    logic [2:0] al_status_code;
    logic       error_pending;

    modport source (
        output valid, current_state, al_status, al_status_code, error_pending,
        input  ready
    );

    modport sink (
        input  valid, current_state, al_status, al_status_code, error_pending,
        output ready
    );
endinterface

@@ rtl/fsalsm_front.sv @@
// ----------------------------------------------------------------------------
// fsalsm_front
// Accepts requests and classifies them into queue entries.
// ----------------------------------------------------------------------------
module fsalsm_front
    import fsalsm_pkg::*;
(
    fsalsm_in_if.sink i_req,
    input  logic      i_q_full,
    output logic      o_push,
    output t_req      o_req
);

    assign i_req.ready = !i_q_full;
    assign o_push      = i_req.valid && !i_q_full;

    always_comb begin
        o_req.al_ctrl = i_req.al_control[5:0];
        o_req.idx     = i_req.entry_index;
        o_req.addr    = i_req.entry_address;
        o_req.len     = i_req.entry_length;
        o_req.active  = i_req.entry_active;
        o_req.ctrl    = i_req.entry_control[3:0];
        case (i_req.command)
            CMD_POLL: begin
                o_req.op = OP_POLL;
            end
            CMD_SM_WR: begin
                o_req.op = OP_SM_WR;
            end
            CMD_MAP_WR: begin
                // A mapping keeps only its read and write type bits.
                o_req.op   = OP_MAP_WR;
                o_req.ctrl = {2'b00, i_req.entry_control[1:0]};
            end
            default: begin
                o_req.op = OP_NONE;
            end
        endcase
    end

endmodule

@@ rtl/fsalsm_queue.sv @@
// ----------------------------------------------------------------------------
// fsalsm_queue
// Short request queue between the front and the back end.
// ----------------------------------------------------------------------------
module fsalsm_queue
    import fsalsm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_req      i_req,
    input  logic      i_pop,
    output t_q_status o_stat,
    output t_req      o_req
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_req             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_stat.valid = (r_count != '0);
    assign o_stat.full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_req        = r_mem[r_rd_ptr];

endmodule

@@ rtl/fsalsm_back.sv @@
// ----------------------------------------------------------------------------
// fsalsm_back
// Executes queued requests: AL state changes, table writes, response register.
// ----------------------------------------------------------------------------
module fsalsm_back
    import fsalsm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    input  t_q_status     i_q_stat,
    input  t_req          i_req,
    output logic          o_pop,
    fsalsm_out_if.source  o_rsp
);

    typedef enum logic [2:0] {
        K_IGNORE,
        K_ERR_ACK,
        K_SAME,
        K_FAIL,
        K_GO
    } t_kind;

    // Configuration registers.
    logic [15:0] r_mbx_out_start, r_mbx_in_start, r_out_start, r_in_start;
    logic [15:0] r_ctrl_nibbles;
    logic [5:0]  r_min_pdo;
    logic        r_skip_checks;

    // Slave state.
    t_al_state   r_state, n_state;
    logic [7:0]  r_status, n_status;
    t_err_code   r_code, n_code;

    // Sync manager and mapping tables; only the active bits need a reset.
    logic [15:0] r_sm_addr [4];
    logic [15:0] r_sm_len  [4];
    logic [3:0]  r_sm_ctrl [4];
    logic [3:0]  r_sm_active;
    logic [15:0] r_map_addr [4];
    logic [15:0] r_map_len  [4];
    logic [1:0]  r_map_ctrl [4];
    logic [3:0]  r_map_active;

    // Response register.
    logic        r_out_valid;
    t_al_state   r_out_state;
    logic [7:0]  r_out_status;
    t_err_code   r_out_code;

    logic [15:0] w_sm_start [4];
    logic [3:0]  w_sm_ok;
    logic [3:0]  w_map_out_hit, w_map_in_hit;
    logic        w_out_map_ok, w_in_map_ok;
    logic [15:0] w_min_pdo;
    logic [3:0]  w_req_state;
    t_kind       w_kind;
    t_err_code   w_fail_code;

    assign o_pop       = i_q_stat.valid && (!r_out_valid || o_rsp.ready);
    assign w_min_pdo   = {10'd0, r_min_pdo};
    assign w_req_state = i_req.al_ctrl[3:0];

    assign w_sm_start[0] = r_mbx_out_start;
    assign w_sm_start[1] = r_mbx_in_start;
    assign w_sm_start[2] = r_out_start;
    assign w_sm_start[3] = r_in_start;

    // All table checks are evaluated in parallel from the stored entries.
    for (genvar g = 0; g < 4; g++) begin : g_checks
        logic w_len_ok;
        if (g < 2) begin : g_mbx
            assign w_len_ok = (r_sm_len[g] >= 16'(MIN_MAILBOX_BYTES));
        end else begin : g_pd
            assign w_len_ok = (r_sm_len[g] >= w_min_pdo) &&
                              (r_sm_len[g] <= 16'(PD_BUFFER_BYTES));
        end
        assign w_sm_ok[g] = (r_sm_addr[g] == w_sm_start[g]) && w_len_ok &&
                            r_sm_active[g] && (r_sm_ctrl[g] == r_ctrl_nibbles[4*g +: 4]);

        assign w_map_out_hit[g] = r_map_active[g] && (r_map_addr[g] == r_out_start) &&
                                  (r_map_len[g] >= w_min_pdo) && r_map_ctrl[g][1];
        assign w_map_in_hit[g]  = r_map_active[g] && (r_map_addr[g] == r_in_start) &&
                                  (r_map_len[g] >= w_min_pdo) && r_map_ctrl[g][0];
    end

    assign w_out_map_ok = |w_map_out_hit;
    assign w_in_map_ok  = |w_map_in_hit;

    // Next state: classify the poll and pick the target state.
    always_comb begin
        w_kind      = K_IGNORE;
        w_fail_code = CODE_NONE;
        n_state     = r_state;
        if (o_pop && i_req.op == OP_POLL) begin
            if (i_req.al_ctrl[AL_ERR_ACK_BIT] && r_code != CODE_NONE) begin
                w_kind = K_ERR_ACK;
            end else if (!is_known_state(w_req_state)) begin
                w_kind = K_IGNORE;
            end else if (w_req_state == r_state) begin
                w_kind = K_SAME;
            end else if (!legal_move(r_state, w_req_state)) begin
                w_kind      = K_FAIL;
                w_fail_code = CODE_BAD_CHANGE;
            end else begin
                if (!r_skip_checks) begin
                    if (r_state == ST_PREOP && w_req_state == ST_SAFEOP) begin
                        if (!w_sm_ok[0] || !w_sm_ok[1]) begin
                            w_fail_code = CODE_MAILBOX;
                        end else if (!w_sm_ok[2]) begin
                            w_fail_code = CODE_OUT_CFG;
                        end else if (!w_sm_ok[3]) begin
                            w_fail_code = CODE_IN_CFG;
                        end
                    end else if (r_state == ST_SAFEOP && w_req_state == ST_OP) begin
                        if (!w_sm_ok[2]) begin
                            w_fail_code = CODE_OUT_CFG;
                        end else if (!w_sm_ok[3]) begin
                            w_fail_code = CODE_IN_CFG;
                        end else if (!w_out_map_ok) begin
                            w_fail_code = CODE_OUT_MAP;
                        end else if (!w_in_map_ok) begin
                            w_fail_code = CODE_IN_MAP;
                        end
                    end
                end
                if (w_fail_code != CODE_NONE) begin
                    w_kind = K_FAIL;
                end else begin
                    w_kind  = K_GO;
                    n_state = t_al_state'(w_req_state);
                end
            end
        end
    end

    // Outputs of the state machine: status byte and status code.
    always_comb begin
        n_status = r_status;
        n_code   = r_code;
        case (w_kind)
            K_ERR_ACK: begin
                n_status = {4'd0, r_state};
                n_code   = CODE_NONE;
            end
            K_SAME: begin
                n_status = {4'd0, r_state};
            end
            K_FAIL: begin
                n_status = {4'd0, r_state};
                n_status[AL_ERR_BIT] = 1'b1;
                n_code   = w_fail_code;
            end
            K_GO: begin
                n_status = {4'd0, w_req_state};
                n_status[AL_ACK_BIT] = i_req.al_ctrl[AL_ACK_BIT];
                n_code   = CODE_NONE;
            end
            default: begin
                n_status = r_status;
                n_code   = r_code;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbx_out_start <= 16'd4096;
            r_mbx_in_start  <= 16'd4224;
            r_out_start     <= 16'd4352;
            r_in_start      <= 16'd4480;
            r_ctrl_nibbles  <= 16'd1062;
            r_min_pdo       <= 6'd4;
            r_skip_checks   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MBX_OUT_START: r_mbx_out_start <= i_cfg_data;
                CFG_MBX_IN_START:  r_mbx_in_start  <= i_cfg_data;
                CFG_OUT_START:     r_out_start     <= i_cfg_data;
                CFG_IN_START:      r_in_start      <= i_cfg_data;
                CFG_CTRL_NIBBLES:  r_ctrl_nibbles  <= i_cfg_data;
                CFG_MIN_PDO:       r_min_pdo       <= i_cfg_data[5:0];
                CFG_SKIP_CHECKS:   r_skip_checks   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_status     <= {4'd0, ST_INIT};
            r_code       <= CODE_NONE;
            r_sm_active  <= '0;
            r_map_active <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_code   <= n_code;
            if (o_pop && i_req.op == OP_SM_WR) begin
                r_sm_active[i_req.idx] <= i_req.active;
            end
            if (o_pop && i_req.op == OP_MAP_WR) begin
                r_map_active[i_req.idx] <= i_req.active;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_req.op == OP_SM_WR) begin
            r_sm_addr[i_req.idx] <= i_req.addr;
            r_sm_len[i_req.idx]  <= i_req.len;
            r_sm_ctrl[i_req.idx] <= i_req.ctrl;
        end
        if (o_pop && i_req.op == OP_MAP_WR) begin
            r_map_addr[i_req.idx] <= i_req.addr;
            r_map_len[i_req.idx]  <= i_req.len;
            r_map_ctrl[i_req.idx] <= i_req.ctrl[1:0];
        end
        if (o_pop) begin
            r_out_state  <= n_state;
            r_out_status <= n_status;
            r_out_code   <= n_code;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.current_state  = r_out_state;
    assign o_rsp.al_status      = r_out_status;
    assign o_rsp.al_status_code = r_out_code;
    assign o_rsp.error_pending  = (r_out_code != CODE_NONE);

endmodule

@@ rtl/fieldbus_slave_al_state_machine.sv @@
// ----------------------------------------------------------------------------
// fieldbus_slave_al_state_machine
// Slave AL state machine with sync manager and mapping checks.
// ----------------------------------------------------------------------------
//  Port         Dir  Handshake      Carries
//  i_req        in   valid/ready    poll or table entry write request
//  o_rsp        out  valid/ready    state, AL status, status code, error flag
//  i_cfg_*      in   write enable   configuration registers 0 to 6
//
// One request is accepted per cycle while the queue is not full. An accepted
// request is written into the queue, and its response is then loaded into the
// response register from the queue head. Requests are refused only while the
// two-entry queue is full, which happens when the response side stalls. Reset
// is synchronous; the tables leave reset inactive and need no clearing pass.
// ----------------------------------------------------------------------------
`include "fieldbus_slave_al_state_machine_assert.svh"

module fieldbus_slave_al_state_machine
    import fsalsm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsalsm_in_if.sink     i_req,
    fsalsm_out_if.source  o_rsp,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data
);

    logic      w_push;
    logic      w_pop;
    t_req      w_front_req;
    t_req      w_back_req;
    t_q_status w_q_stat;

    fsalsm_front u_front (
        .i_req    (i_req),
        .i_q_full (w_q_stat.full),
        .o_push   (w_push),
        .o_req    (w_front_req)
    );

    fsalsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_front_req),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_req   (w_back_req)
    );

    fsalsm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .i_req       (w_back_req),
        .o_pop       (w_pop),
        .o_rsp       (o_rsp)
    );

    // The status byte always carries the current state in its low nibble.
    `FSALSM_ASSERT(a_status_state, o_rsp.valid |-> (o_rsp.al_status[3:0] == o_rsp.current_state), "AL status nibble differs from state")
    // An error flag in the status byte implies a held error code.
    `FSALSM_ASSERT(a_err_flag, (o_rsp.valid && o_rsp.al_status[5]) |-> o_rsp.error_pending, "error flag without pending error")
    `FSALSM_ASSERT_ALWAYS(a_rst_rsp, !i_rst_n |=> !o_rsp.valid, "response valid after reset")
    `FSALSM_ASSERT_ALWAYS(a_rst_queue, !i_rst_n |=> !w_q_stat.valid, "queue not empty after reset")

endmodule

@@ dv/fieldbus_slave_al_state_machine_tb.sv @@
// ----------------------------------------------------------------------------
// fieldbus_slave_al_state_machine_tb
// Drives AL control polls and sync manager and mapping writes into the AL
// state machine and compares every response with a cycle-free prediction.
// ----------------------------------------------------------------------------
module fieldbus_slave_al_state_machine_tb;
    import fsalsm_pkg::*;

    // Predicts the slave state and AL status after each request and holds
    // the reports still to come back from the block.
    class al_status_scoreboard;
        typedef struct packed {
            logic [15:0] addr;
            logic [15:0] len;
            logic [3:0]  ctrl;
            logic        active;
        } t_entry;

        typedef struct packed {
            logic [3:0] state;
            logic [7:0] status;
            logic [2:0] code;
            logic       pending;
        } t_al_report;

        logic [15:0] mbx_out_start, mbx_in_start, out_start, in_start;
        logic [15:0] ctrl_nibbles;
        logic [5:0]  min_pdo;
        logic        skip_checks;

        logic [3:0] slave_state;
        logic [2:0] held_error;
        logic [7:0] status_byte;
        logic [2:0] status_code;
        t_entry     sm_tbl[4];
        t_entry     map_tbl[4];

        t_al_report  expected_reports[$];
        int unsigned failures;

        function new();
            mbx_out_start = 16'd4096;
            mbx_in_start  = 16'd4224;
            out_start     = 16'd4352;
            in_start      = 16'd4480;
            ctrl_nibbles  = 16'd1062;
            min_pdo       = 6'd4;
            skip_checks   = 1'b0;
            slave_state   = ST_INIT;
            held_error    = CODE_NONE;
            status_byte   = {4'h0, ST_INIT};
            status_code   = CODE_NONE;
            failures      = 0;
            for (int i = 0; i < 4; i++) begin
                sm_tbl[i]  = '0;
                map_tbl[i] = '0;
            end
        endfunction

        function int unsigned waiting();
            return expected_reports.size();
        endfunction

        function logic [15:0] sm_start(logic [1:0] idx);
            case (idx)
                2'd0:    return mbx_out_start;
                2'd1:    return mbx_in_start;
                2'd2:    return out_start;
                default: return in_start;
            endcase
        endfunction

        function void set_register(logic [2:0] index, logic [15:0] value);
            case (index)
                CFG_MBX_OUT_START: mbx_out_start = value;
                CFG_MBX_IN_START:  mbx_in_start  = value;
                CFG_OUT_START:     out_start     = value;
                CFG_IN_START:      in_start      = value;
                CFG_CTRL_NIBBLES:  ctrl_nibbles  = value;
                CFG_MIN_PDO:       min_pdo       = value[5:0];
                CFG_SKIP_CHECKS:   skip_checks   = value[0];
                default: ;
            endcase
        endfunction

        function bit sm_entry_ok(int n, logic [15:0] start, logic [15:0] min_len,
                                 logic [15:0] max_len);
            return sm_tbl[n].active && sm_tbl[n].addr == start &&
                   sm_tbl[n].len >= min_len && sm_tbl[n].len <= max_len &&
                   sm_tbl[n].ctrl == ctrl_nibbles[4*n +: 4];
        endfunction

        function logic [2:0] mailbox_fault();
            if (!sm_entry_ok(0, mbx_out_start, 16'(MIN_MAILBOX_BYTES), 16'hFFFF))
                return CODE_MAILBOX;
            if (!sm_entry_ok(1, mbx_in_start, 16'(MIN_MAILBOX_BYTES), 16'hFFFF))
                return CODE_MAILBOX;
            return CODE_NONE;
        endfunction

        function logic [2:0] process_fault();
            if (!sm_entry_ok(2, out_start, {10'd0, min_pdo}, 16'(PD_BUFFER_BYTES)))
                return CODE_OUT_CFG;
            if (!sm_entry_ok(3, in_start, {10'd0, min_pdo}, 16'(PD_BUFFER_BYTES)))
                return CODE_IN_CFG;
            return CODE_NONE;
        endfunction

        function logic [2:0] mapping_fault();
            bit out_ok, in_ok;
            out_ok = 1'b0;
            in_ok  = 1'b0;
            for (int i = 0; i < 4; i++) begin
                if (map_tbl[i].active && map_tbl[i].len >= {10'd0, min_pdo}) begin
                    if (map_tbl[i].addr == out_start && map_tbl[i].ctrl[1]) out_ok = 1'b1;
                    if (map_tbl[i].addr == in_start && map_tbl[i].ctrl[0]) in_ok = 1'b1;
                end
            end
            if (!out_ok) return CODE_OUT_MAP;
            if (!in_ok) return CODE_IN_MAP;
            return CODE_NONE;
        endfunction

        function void apply_poll(logic [7:0] ctrl);
            logic [3:0] want;
            logic [2:0] fault;
            bit         known, legal;
            want  = ctrl[3:0];
            fault = CODE_NONE;
            // An error acknowledge with an error held does nothing else.
            if (ctrl[AL_ERR_ACK_BIT] && held_error != CODE_NONE) begin
                held_error  = CODE_NONE;
                status_code = CODE_NONE;
                status_byte = {4'h0, slave_state};
                return;
            end
            known = (want == ST_INIT) || (want == ST_PREOP) || (want == ST_BOOT) ||
                    (want == ST_SAFEOP) || (want == ST_OP);
            if (!known) return;
            // Repeating the current state re-reports it but keeps any error.
            if (want == slave_state) begin
                status_byte = {4'h0, slave_state};
                return;
            end
            case (slave_state)
                ST_INIT:   legal = (want == ST_PREOP);
                ST_PREOP:  legal = (want == ST_SAFEOP);
                ST_SAFEOP: legal = (want == ST_OP) || (want == ST_PREOP);
                ST_OP:     legal = (want == ST_SAFEOP);
                default:   legal = 1'b0;
            endcase
            legal = legal || (want == ST_INIT);
            if (!legal) begin
                fault = CODE_BAD_CHANGE;
            end else if (!skip_checks) begin
                if (slave_state == ST_PREOP && want == ST_SAFEOP) begin
                    fault = mailbox_fault();
                    if (fault == CODE_NONE) fault = process_fault();
                end else if (slave_state == ST_SAFEOP && want == ST_OP) begin
                    fault = process_fault();
                    if (fault == CODE_NONE) fault = mapping_fault();
                end
            end
            if (fault != CODE_NONE) begin
                held_error  = fault;
                status_code = fault;
                status_byte = {4'h0, slave_state};
                status_byte[AL_ERR_BIT] = 1'b1;
            end else begin
                slave_state = want;
                held_error  = CODE_NONE;
                status_code = CODE_NONE;
                status_byte = {4'h0, want};
                status_byte[AL_ACK_BIT] = ctrl[AL_ACK_BIT];
            end
        endfunction

        function void note_request(logic [1:0] cmd, logic [7:0] al_ctrl, logic [1:0] idx,
                                   logic [15:0] addr, logic [15:0] len,
                                   logic [7:0] ectrl, logic act);
            t_al_report rpt;
            case (cmd)
                CMD_POLL:   apply_poll(al_ctrl);
                CMD_SM_WR:  sm_tbl[idx]  = '{addr, len, ectrl[3:0], act};
                CMD_MAP_WR: map_tbl[idx] = '{addr, len, {2'b00, ectrl[1:0]}, act};
                default: ;
            endcase
            rpt.state   = slave_state;
            rpt.status  = status_byte;
            rpt.code    = status_code;
            rpt.pending = (held_error != CODE_NONE);
            expected_reports.push_back(rpt);
        endfunction

        function void check_report(logic [3:0] state, logic [7:0] status, logic [2:0] code,
                                   logic pending);
            t_al_report want;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected response: state %h status %h code %0d pending %b",
                         $time, state, status, code, pending);
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            if (state !== want.state) begin
                $display("%0t: current_state expected %h got %h", $time, want.state, state);
                failures++;
            end
            if (status !== want.status) begin
                $display("%0t: al_status expected %h got %h", $time, want.status, status);
                failures++;
            end
            if (code !== want.code) begin
                $display("%0t: al_status_code expected %0d got %0d", $time, want.code, code);
                failures++;
            end
            if (pending !== want.pending) begin
                $display("%0t: error_pending expected %b got %b", $time, want.pending, pending);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    int unsigned long_hold_req = 0;

    al_status_scoreboard status_sb;

    fsalsm_in_if  req_if ();
    fsalsm_out_if rsp_if ();

    fieldbus_slave_al_state_machine uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                status_sb.note_request(req_if.command, req_if.al_control, req_if.entry_index,
                                       req_if.entry_address, req_if.entry_length,
                                       req_if.entry_control, req_if.entry_active);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                status_sb.check_report(rsp_if.current_state, rsp_if.al_status,
                                       rsp_if.al_status_code, rsp_if.error_pending);
            end
        end
    end

    // Response side: switches between stall patterns, and on request holds
    // off for a long stretch so that the request queue fills up.
    initial begin : response_sink
        int unsigned mode, mode_left, hold_left, hold_seen;
        logic [7:0]  pattern;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_seen = 0;
        pattern   = 8'b1011_0010;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req != hold_seen) begin
                hold_seen = long_hold_req;
                hold_left = 64;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                pattern = {pattern[6:0], pattern[7]};
                case (mode)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_if.ready <= pattern[0];
                    default: rsp_if.ready <= ($urandom_range(0, 5) != 0);
                endcase
            end
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] al_ctrl,
                                input logic [1:0] idx, input logic [15:0] addr,
                                input logic [15:0] len, input logic [7:0] ectrl,
                                input logic act);
        req_if.valid         <= 1'b1;
        req_if.command       <= cmd;
        req_if.al_control    <= al_ctrl;
        req_if.entry_index   <= idx;
        req_if.entry_address <= addr;
        req_if.entry_length  <= len;
        req_if.entry_control <= ectrl;
        req_if.entry_active  <= act;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic idle_request(input int unsigned cycles);
        req_if.valid         <= 1'b0;
        req_if.command       <= 2'($urandom);
        req_if.al_control    <= 8'($urandom);
        req_if.entry_address <= 16'($urandom);
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (status_sb.waiting() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
        status_sb.set_register(index, value);
    endtask

    task automatic apply_settings(input logic [15:0] mbx_out, input logic [15:0] mbx_in,
                                  input logic [15:0] outs, input logic [15:0] ins,
                                  input logic [15:0] nibbles, input logic [5:0] min_len,
                                  input logic skip);
        drain_results();
        write_register(CFG_MBX_OUT_START, mbx_out);
        write_register(CFG_MBX_IN_START, mbx_in);
        write_register(CFG_OUT_START, outs);
        write_register(CFG_IN_START, ins);
        write_register(CFG_CTRL_NIBBLES, nibbles);
        write_register(CFG_MIN_PDO, {10'd0, min_len});
        write_register(CFG_SKIP_CHECKS, {15'd0, skip});
        cfg_we <= 1'b0;
    endtask

    // Sync manager entry whose address and control match the current settings for its index.
    task automatic write_sync_manager_ok(input logic [1:0] idx, input logic [15:0] len);
        logic [7:0] ectrl;
        ectrl = 8'($urandom);
        ectrl[3:0] = status_sb.ctrl_nibbles[4*idx +: 4];
        send_request(CMD_SM_WR, 8'($urandom), idx, status_sb.sm_start(idx), len, ectrl, 1'b1);
    endtask

    task automatic write_mapping_ok(input logic [1:0] idx, input bit to_outputs,
                                    input logic [15:0] len);
        logic [7:0]  ectrl;
        logic [15:0] addr;
        ectrl = 8'($urandom);
        if (to_outputs) begin
            ectrl[1] = 1'b1;
            addr = status_sb.out_start;
        end else begin
            ectrl[0] = 1'b1;
            addr = status_sb.in_start;
        end
        send_request(CMD_MAP_WR, 8'($urandom), idx, addr, len, ectrl, 1'b1);
    endtask

    task automatic poll(input logic [7:0] al_ctrl);
        send_request(CMD_POLL, al_ctrl, 2'($urandom), 16'($urandom), 16'($urandom),
                     8'($urandom), 1'($urandom));
    endtask

    // Mostly the next legal state, with repeats, Boot, Init and junk mixed in.
    function automatic logic [3:0] pick_target();
        int unsigned r;
        logic [3:0]  now;
        r   = $urandom_range(0, 11);
        now = status_sb.slave_state;
        case (r)
            0, 1:    return 4'($urandom);
            2:       return ST_INIT;
            3:       return now;
            4:       return ST_BOOT;
            default: begin
                case (now)
                    ST_INIT:   return ST_PREOP;
                    ST_PREOP:  return ST_SAFEOP;
                    ST_SAFEOP: return (r < 7) ? ST_PREOP : ST_OP;
                    ST_OP:     return (r < 6) ? ST_INIT : ST_SAFEOP;
                    default:   return ST_INIT;
                endcase
            end
        endcase
    endfunction

    task automatic random_request();
        int unsigned pick;
        logic [1:0]  idx;
        logic [7:0]  ctrl;
        logic [15:0] len;
        pick = $urandom_range(0, 99);
        idx  = 2'($urandom);
        if (pick < 40) begin
            ctrl = 8'($urandom);
            ctrl[3:0] = pick_target();
            ctrl[AL_ERR_ACK_BIT] = ($urandom_range(0, 3) == 0);
            poll(ctrl);
        end else if (pick < 65) begin
            if (idx < 2) begin
                if ($urandom_range(0, 7) == 0) len = 16'hFFFF;
                else len = 16'($urandom_range(MIN_MAILBOX_BYTES - 1, MIN_MAILBOX_BYTES + 6));
            end else begin
                case ($urandom_range(0, 9))
                    0:       len = {10'd0, status_sb.min_pdo - 6'd1};
                    1:       len = 16'(PD_BUFFER_BYTES + 1);
                    default: len = 16'($urandom_range(status_sb.min_pdo, PD_BUFFER_BYTES));
                endcase
            end
            write_sync_manager_ok(idx, len);
        end else if (pick < 85) begin
            write_mapping_ok(idx, 1'($urandom_range(0, 1)),
                             16'($urandom_range(status_sb.min_pdo, 40)));
        end else if (pick < 92) begin
            send_request($urandom_range(0, 1) ? CMD_SM_WR : CMD_MAP_WR, 8'($urandom), idx,
                         16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        end else begin
            send_request(2'($urandom), 8'($urandom), idx, 16'($urandom), 16'($urandom),
                         8'($urandom), 1'($urandom));
        end
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned sent, burst;
        bit          calm;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 16);
            calm  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst; k++) begin
                random_request();
                sent++;
                if (sent == count / 3) long_hold_req++;
                if (sent == (2 * count) / 3) drain_results();
            end
            if (!calm) idle_request($urandom_range(1, 6));
        end
    endtask

    // Walks from Init to Op under the reset settings, hitting each check
    // failure in its order of priority on the way.
    task automatic directed_sequence();
        poll(8'h00);
        poll(8'hCF);
        poll({4'h1, ST_INIT});
        poll({4'h0, ST_SAFEOP});
        poll({4'h2, ST_PREOP});
        poll({4'h0, ST_BOOT});
        poll({4'h0, ST_INIT});
        poll({4'h2, ST_INIT});
        poll({4'h1, ST_PREOP});
        poll({4'h0, ST_OP});
        poll({4'h1, ST_SAFEOP});
        write_sync_manager_ok(2'd0, 16'(MIN_MAILBOX_BYTES));
        write_sync_manager_ok(2'd1, 16'hFFFF);
        poll({4'h1, ST_SAFEOP});
        write_sync_manager_ok(2'd2, 16'(PD_BUFFER_BYTES));
        poll({4'h1, ST_SAFEOP});
        write_sync_manager_ok(2'd3, {10'd0, status_sb.min_pdo});
        poll({4'h1, ST_SAFEOP});
        poll({4'h0, ST_OP});
        write_mapping_ok(2'd0, 1'b1, {10'd0, status_sb.min_pdo});
        poll({4'h0, ST_OP});
        write_mapping_ok(2'd3, 1'b0, 16'hFFFF);
        send_request(2'(OP_NONE), 8'hFF, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
        poll({4'h1, ST_OP});
        poll({4'hC, ST_INIT});
    endtask

    initial begin : stimulus
        status_sb = new();
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_MBX_OUT_START;
        cfg_data             <= '0;
        req_if.valid         <= 1'b0;
        req_if.command       <= CMD_POLL;
        req_if.al_control    <= '0;
        req_if.entry_index   <= '0;
        req_if.entry_address <= '0;
        req_if.entry_length  <= '0;
        req_if.entry_control <= '0;
        req_if.entry_active  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_sequence();
        run_random(150);
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd32, 1'b0);
        run_random(120);
        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 6'd1, 1'b1);
        run_random(100);
        apply_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                       16'($urandom), 6'($urandom_range(1, 32)), 1'b0);
        run_random(130);

        drain_results();
        repeat (8) @(posedge i_clk);
        if (status_sb.failures == 0 && status_sb.waiting() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
